@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

`endif

@@ rtl/fds_pkg.sv @@
// ----------------------------------------------------------------------------
// fds_pkg
// types and constants shared by the flat diffuse shader
// ----------------------------------------------------------------------------
`default_nettype none

package fds_pkg;

    localparam int MAG_W      = 17;
    localparam int LEN2_W     = 34;
    localparam int ROOT_W     = 31;
    localparam int REM_W      = 33;
    localparam int SQRT_STEPS = 31;
    localparam int QUO_W      = 15;
    localparam int DIV_STEPS  = 15;
    localparam int DREM_W     = 32;

    localparam logic MODE_FLAT = 1'b0;
    localparam logic MODE_PASS = 1'b1;

    typedef enum logic [1:0] {
        KIND_AMBIENT  = 2'd0,
        KIND_POINT    = 2'd1,
        KIND_INFINITE = 2'd2,
        KIND_SPOT     = 2'd3
    } fds_kind_t;

    typedef enum logic [2:0] {
        REG_KIND      = 3'd0,
        REG_MODE      = 3'd1,
        REG_LEVEL     = 3'd2,
        REG_POSITION  = 3'd3,
        REG_DIRECTION = 3'd4,
        REG_COS       = 3'd5
    } fds_reg_t;

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] point_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [7:0]         color_red;
        logic [7:0]         color_green;
        logic [7:0]         color_blue;
    } fds_item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } fds_result_t;

    // surface data that rides along the pipeline
    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [7:0]         color_red;
        logic [7:0]         color_green;
        logic [7:0]         color_blue;
    } fds_surf_t;

    typedef struct packed {
        fds_surf_t              surf;
        logic [2:0][MAG_W-1:0]  mag;
        logic [2:0]             neg;
    } fds_vside_t;

endpackage

`default_nettype wire

@@ rtl/flat_diffuse_shader_unit.sv @@
// ----------------------------------------------------------------------------
// flat_diffuse_shader_unit
// flat lambert shading of one face per transaction with four light kinds
// ----------------------------------------------------------------------------
// a new face is taken on every cycle in which start is high (busy never rises)
// and its colour appears on result with done high for one cycle; the receiver
// cannot stall, and none is needed since the pipeline never holds. the pipeline
// has the 31-stage square root of the light vector length and the 15-stage
// divider that normalises the vector; three stages form the vector and five
// more do the dot products and colour scaling. settings are to be written over
// the apb port only while no transaction is in flight; the block does not enforce this.
`default_nettype none
`include "assert_macros.svh"

module flat_diffuse_shader_unit
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // transaction side
    input  wire logic                  start,
    output logic                       busy,
    input  wire fds_pkg::fds_item_t    item,
    output logic                       done,
    output fds_pkg::fds_result_t       result,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [5:0]            paddr,
    input  wire logic [63:0]           pwdata,
    output logic [63:0]                prdata,
    output logic                       pready
);

    // settings
    fds_pkg::fds_kind_t            light_kind_reg;
    logic                          shade_mode_reg;
    logic [15:0]                   light_level_reg;
    logic [47:0]                   light_position_reg;
    logic [47:0]                   light_direction_reg;
    logic [15:0]                   spot_cos_half_reg;
    logic                          cfg_wr;
    fds_pkg::fds_reg_t             cfg_idx;

    // inter-stage links
    logic                          vec_valid;
    logic [fds_pkg::LEN2_W-1:0]    vec_len2;
    fds_pkg::fds_vside_t           vec_side;
    logic                          sq_valid;
    logic [fds_pkg::ROOT_W-1:0]    sq_root;
    logic                          sq_zero;
    fds_pkg::fds_vside_t           sq_side;
    logic                          dv_valid;
    logic [2:0][15:0]              dv_lvec;
    fds_pkg::fds_surf_t            dv_surf;

    // registers sit on 8-byte boundaries, index in the upper address bits
    assign cfg_idx = fds_pkg::fds_reg_t'(paddr[5:3]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;
    // fully pipelined, so a new transaction is always welcome
    assign busy    = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_kind_reg      <= fds_pkg::KIND_POINT;
            shade_mode_reg      <= fds_pkg::MODE_FLAT;
            light_level_reg     <= 16'd16384;
            light_position_reg  <= '0;
            light_direction_reg <= '0;
            spot_cos_half_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                fds_pkg::REG_KIND:      light_kind_reg <= fds_pkg::fds_kind_t'(pwdata[1:0]);
                fds_pkg::REG_MODE:      shade_mode_reg      <= pwdata[0];
                fds_pkg::REG_LEVEL:     light_level_reg     <= pwdata[15:0];
                fds_pkg::REG_POSITION:  light_position_reg  <= pwdata[47:0];
                fds_pkg::REG_DIRECTION: light_direction_reg <= pwdata[47:0];
                fds_pkg::REG_COS:       spot_cos_half_reg   <= pwdata[15:0];
                default:                ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (cfg_idx)
            fds_pkg::REG_KIND:      prdata = {62'b0, light_kind_reg};
            fds_pkg::REG_MODE:      prdata = {63'b0, shade_mode_reg};
            fds_pkg::REG_LEVEL:     prdata = {48'b0, light_level_reg};
            fds_pkg::REG_POSITION:  prdata = {16'b0, light_position_reg};
            fds_pkg::REG_DIRECTION: prdata = {16'b0, light_direction_reg};
            fds_pkg::REG_COS:       prdata = {48'b0, spot_cos_half_reg};
            default:                prdata = '0;
        endcase
    end

    // light vector and its squared length
    fds_vec u_vec
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .item      (item),
        .kind      (light_kind_reg),
        .position  (light_position_reg),
        .direction (light_direction_reg),
        .out_valid (vec_valid),
        .len2      (vec_len2),
        .side      (vec_side)
    );

    // length, scaled to q.14
    fds_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vec_valid),
        .len2      (vec_len2),
        .side_in   (vec_side),
        .out_valid (sq_valid),
        .root      (sq_root),
        .zero      (sq_zero),
        .side_out  (sq_side)
    );

    // normalise each component
    fds_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .root      (sq_root),
        .zero      (sq_zero),
        .side_in   (sq_side),
        .out_valid (dv_valid),
        .lvec      (dv_lvec),
        .surf      (dv_surf)
    );

    // dot products, cone test and channel scaling
    fds_shade u_shade
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid),
        .lvec      (dv_lvec),
        .surf      (dv_surf),
        .kind      (light_kind_reg),
        .mode      (shade_mode_reg),
        .level     (light_level_reg),
        .direction (light_direction_reg),
        .cos_half  (spot_cos_half_reg),
        .done      (done),
        .result    (result)
    );

    // a completed write lands in the addressed register
    `ASSERT_NEXT(a_kind_write, clk, rst_n, cfg_wr && (cfg_idx == fds_pkg::REG_KIND), light_kind_reg == $past(pwdata[1:0]))
    `ASSERT_NEXT(a_level_write, clk, rst_n, cfg_wr && (cfg_idx == fds_pkg::REG_LEVEL), light_level_reg == $past(pwdata[15:0]))
    `ASSERT_SAME(a_never_busy, clk, rst_n, start, !busy)

endmodule

`default_nettype wire

@@ rtl/fds_vec.sv @@
// ----------------------------------------------------------------------------
// fds_vec
// light vector components, their squares and the squared length
// ----------------------------------------------------------------------------
`default_nettype none

module fds_vec
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire fds_pkg::fds_item_t         item,
    input  wire fds_pkg::fds_kind_t         kind,
    input  wire logic [47:0]                position,
    input  wire logic [47:0]                direction,
    output logic                            out_valid,
    output logic [fds_pkg::LEN2_W-1:0]      len2,
    output fds_pkg::fds_vside_t             side
);

    logic signed [15:0]          pt [3];
    logic signed [16:0]          d  [3];
    fds_pkg::fds_vside_t         a_side_next;
    fds_pkg::fds_vside_t         a_side_reg;
    fds_pkg::fds_vside_t         b_side_reg;
    fds_pkg::fds_vside_t         c_side_reg;
    logic                        a_valid_reg;
    logic                        b_valid_reg;
    logic                        c_valid_reg;
    logic [2*fds_pkg::MAG_W-1:0] sq_reg [3];
    logic [fds_pkg::LEN2_W-1:0]  len2_reg;

    always_comb
    begin
        pt[0] = item.point_x;
        pt[1] = item.point_y;
        pt[2] = item.point_z;
        a_side_next.surf.normal_x    = item.normal_x;
        a_side_next.surf.normal_y    = item.normal_y;
        a_side_next.surf.normal_z    = item.normal_z;
        a_side_next.surf.color_red   = item.color_red;
        a_side_next.surf.color_green = item.color_green;
        a_side_next.surf.color_blue  = item.color_blue;
        for (int i = 0; i < 3; i++)
        begin
            if (kind == fds_pkg::KIND_INFINITE)
            begin
                d[i] = -$signed({direction[16*i+15], direction[16*i +: 16]});
            end
            else
            begin
                d[i] = $signed({position[16*i+15], position[16*i +: 16]})
                     - $signed({pt[i][15], pt[i]});
            end
            a_side_next.neg[i] = d[i][16];
            a_side_next.mag[i] = d[i][16] ? 17'(-d[i]) : 17'(d[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_side_reg <= a_side_next;
        b_side_reg <= a_side_reg;
        c_side_reg <= b_side_reg;
        for (int i = 0; i < 3; i++)
        begin
            sq_reg[i] <= a_side_reg.mag[i] * a_side_reg.mag[i];
        end
        len2_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
    end

    assign out_valid = c_valid_reg;
    assign len2      = len2_reg;
    assign side      = c_side_reg;

endmodule

`default_nettype wire

@@ rtl/fds_sqrt.sv @@
// ----------------------------------------------------------------------------
// fds_sqrt
// pipelined integer square root of len2 * 2^28, one root bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module fds_sqrt
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic [fds_pkg::LEN2_W-1:0] len2,
    input  wire fds_pkg::fds_vside_t        side_in,
    output logic                            out_valid,
    output logic [fds_pkg::ROOT_W-1:0]      root,
    output logic                            zero,
    output fds_pkg::fds_vside_t             side_out
);

    localparam int N = fds_pkg::SQRT_STEPS;

    logic                          v_reg    [N];
    logic [fds_pkg::LEN2_W-1:0]    rad_reg  [N];
    logic [fds_pkg::REM_W-1:0]     rem_reg  [N];
    logic [fds_pkg::ROOT_W-1:0]    root_reg [N];
    logic                          zero_reg [N];
    fds_pkg::fds_vside_t           side_reg [N];

    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic                         v_prev;
        logic [fds_pkg::LEN2_W-1:0]   rad_prev;
        logic [fds_pkg::REM_W-1:0]    rem_prev;
        logic [fds_pkg::ROOT_W-1:0]   root_prev;
        logic                         zero_prev;
        fds_pkg::fds_vside_t          side_prev;
        logic [fds_pkg::REM_W+1:0]    cat;
        logic [fds_pkg::REM_W+1:0]    trial;
        logic [fds_pkg::REM_W+1:0]    diff;
        logic                         ge;

        if (k == 0)
        begin : g_first
            assign v_prev    = in_valid;
            assign rad_prev  = len2;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign zero_prev = (len2 == '0);
            assign side_prev = side_in;
        end
        else
        begin : g_next
            assign v_prev    = v_reg[k-1];
            assign rad_prev  = rad_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign zero_prev = zero_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        // next radicand pair, then zeros from the 2^28 scaling
        assign cat   = {rem_prev, rad_prev[fds_pkg::LEN2_W-1 -: 2]};
        assign trial = {2'b00, root_prev, 2'b01};
        assign ge    = (cat >= trial);
        assign diff  = cat - trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else
            begin
                v_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            rad_reg[k]  <= {rad_prev[fds_pkg::LEN2_W-3:0], 2'b00};
            rem_reg[k]  <= ge ? diff[fds_pkg::REM_W-1:0] : cat[fds_pkg::REM_W-1:0];
            root_reg[k] <= {root_prev[fds_pkg::ROOT_W-2:0], ge};
            zero_reg[k] <= zero_prev;
            side_reg[k] <= side_prev;
        end
    end

    assign out_valid = v_reg[N-1];
    assign root      = root_reg[N-1];
    assign zero      = zero_reg[N-1];
    assign side_out  = side_reg[N-1];

endmodule

`default_nettype wire

@@ rtl/fds_div.sv @@
// ----------------------------------------------------------------------------
// fds_div
// three-lane pipelined divider giving the unit light vector
// ----------------------------------------------------------------------------
`default_nettype none

module fds_div
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic [fds_pkg::ROOT_W-1:0] root,
    input  wire logic                       zero,
    input  wire fds_pkg::fds_vside_t        side_in,
    output logic                            out_valid,
    output logic [2:0][15:0]                lvec,
    output fds_pkg::fds_surf_t              surf
);

    localparam int N = fds_pkg::DIV_STEPS;

    logic                                  v_reg    [N];
    logic [2:0][fds_pkg::DREM_W-1:0]       r_reg    [N];
    logic [2:0][fds_pkg::QUO_W-1:0]        q_reg    [N];
    logic [fds_pkg::ROOT_W-1:0]            s_reg    [N];
    logic                                  zero_reg [N];
    logic [2:0]                            neg_reg  [N];
    fds_pkg::fds_surf_t                    surf_reg [N];

    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic                               v_prev;
        logic [2:0][fds_pkg::DREM_W-1:0]    r_prev;
        logic [2:0][fds_pkg::QUO_W-1:0]     q_prev;
        logic [fds_pkg::ROOT_W-1:0]         s_prev;
        logic                               zero_prev;
        logic [2:0]                         neg_prev;
        fds_pkg::fds_surf_t                 surf_prev;
        logic [2:0][fds_pkg::DREM_W-1:0]    r_next;
        logic [2:0][fds_pkg::QUO_W-1:0]     q_next;
        logic [fds_pkg::DREM_W:0]           cat;
        logic [fds_pkg::DREM_W:0]           diff;
        logic                               ge;

        if (k == 0)
        begin : g_first
            // dividend is mag * 2^28, quotient fits 15 bits
            for (genvar j = 0; j < 3; j++)
            begin : g_lane
                assign r_prev[j] = {2'b00, side_in.mag[j], 13'b0};
            end
            assign v_prev    = in_valid;
            assign q_prev    = '0;
            assign s_prev    = root;
            assign zero_prev = zero;
            assign neg_prev  = side_in.neg;
            assign surf_prev = side_in.surf;
        end
        else
        begin : g_next
            assign v_prev    = v_reg[k-1];
            assign r_prev    = r_reg[k-1];
            assign q_prev    = q_reg[k-1];
            assign s_prev    = s_reg[k-1];
            assign zero_prev = zero_reg[k-1];
            assign neg_prev  = neg_reg[k-1];
            assign surf_prev = surf_reg[k-1];
        end

        always_comb
        begin
            cat    = '0;
            diff   = '0;
            ge     = 1'b0;
            r_next = '0;
            q_next = '0;
            for (int j = 0; j < 3; j++)
            begin
                cat       = {r_prev[j], 1'b0};
                diff      = cat - {2'b00, s_prev};
                ge        = (cat >= {2'b00, s_prev});
                r_next[j] = ge ? diff[fds_pkg::DREM_W-1:0] : cat[fds_pkg::DREM_W-1:0];
                q_next[j] = {q_prev[j][fds_pkg::QUO_W-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else
            begin
                v_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            r_reg[k]    <= r_next;
            q_reg[k]    <= q_next;
            s_reg[k]    <= s_prev;
            zero_reg[k] <= zero_prev;
            neg_reg[k]  <= neg_prev;
            surf_reg[k] <= surf_prev;
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (zero_reg[N-1])
            begin
                lvec[j] = '0;
            end
            else if (neg_reg[N-1][j])
            begin
                lvec[j] = 16'(-{1'b0, q_reg[N-1][j]});
            end
            else
            begin
                lvec[j] = {1'b0, q_reg[N-1][j]};
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign surf      = surf_reg[N-1];

endmodule

`default_nettype wire

@@ rtl/fds_shade.sv @@
// ----------------------------------------------------------------------------
// fds_shade
// dot products, spot cone test and per-channel colour scaling
// ----------------------------------------------------------------------------
`default_nettype none

module fds_shade
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic [2:0][15:0]      lvec,
    input  wire fds_pkg::fds_surf_t    surf,
    input  wire fds_pkg::fds_kind_t    kind,
    input  wire logic                  mode,
    input  wire logic [15:0]           level,
    input  wire logic [47:0]           direction,
    input  wire logic [15:0]           cos_half,
    output logic                       done,
    output fds_pkg::fds_result_t       result
);

    logic signed [15:0]  nrm [3];
    logic signed [31:0]  nl_reg [3];
    logic signed [31:0]  sd_reg [3];
    logic signed [33:0]  dot_next;
    logic signed [33:0]  spot_next;
    logic signed [33:0]  thr;
    logic signed [33:0]  dot_reg;
    logic                inside_next;
    logic                inside2_reg;
    logic                inside3_reg;
    logic                inside4_reg;
    logic signed [50:0]  ld_reg;
    logic signed [51:0]  t;
    logic                tneg_reg;
    logic [58:0]         prod_reg [3];
    logic [23:0]         amb_reg [3];
    logic [7:0]          col [3];
    logic [7:0]          col4 [3];
    logic [7:0]          out_next [3];
    logic [15:0]         lit_hi;
    fds_pkg::fds_surf_t  surf1_reg;
    fds_pkg::fds_surf_t  surf2_reg;
    fds_pkg::fds_surf_t  surf3_reg;
    fds_pkg::fds_surf_t  surf4_reg;
    logic                v1_reg;
    logic                v2_reg;
    logic                v3_reg;
    logic                v4_reg;
    logic                done_reg;
    fds_pkg::fds_result_t result_reg;

    always_comb
    begin
        nrm[0] = surf.normal_x;
        nrm[1] = surf.normal_y;
        nrm[2] = surf.normal_z;
        col4[0] = surf4_reg.color_red;
        col4[1] = surf4_reg.color_green;
        col4[2] = surf4_reg.color_blue;
        col[0] = surf3_reg.color_red;
        col[1] = surf3_reg.color_green;
        col[2] = surf3_reg.color_blue;
    end

    // stage 2: sums and cone test; spot dot uses the negated light vector
    always_comb
    begin
        dot_next  = 34'(nl_reg[0]) + 34'(nl_reg[1]) + 34'(nl_reg[2]);
        spot_next = -(34'(sd_reg[0]) + 34'(sd_reg[1]) + 34'(sd_reg[2]));
        thr       = $signed({{4{cos_half[15]}}, cos_half, 14'b0});
        inside_next = (kind != fds_pkg::KIND_SPOT) || (spot_next >= thr);
    end

    assign t = (52'sd1 <<< 42) + 52'(ld_reg);

    always_comb
    begin
        lit_hi = '0;
        for (int i = 0; i < 3; i++)
        begin
            lit_hi = prod_reg[i][58:43];
            if (mode == fds_pkg::MODE_PASS)
            begin
                out_next[i] = col4[i];
            end
            else if (kind == fds_pkg::KIND_AMBIENT)
            begin
                out_next[i] = amb_reg[i][23] ? 8'd255 : amb_reg[i][22:15];
            end
            else if (!inside4_reg)
            begin
                out_next[i] = {1'b0, col4[i][7:1]};
            end
            else if (tneg_reg)
            begin
                out_next[i] = 8'd0;
            end
            else
            begin
                out_next[i] = (lit_hi > 16'd255) ? 8'd255 : lit_hi[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            done_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            nl_reg[i] <= nrm[i] * $signed(lvec[i]);
            sd_reg[i] <= $signed(direction[16*i +: 16]) * $signed(lvec[i]);
            prod_reg[i] <= col[i] * 51'(t);
            amb_reg[i]  <= col[i] * level;
        end
        surf1_reg   <= surf;
        surf2_reg   <= surf1_reg;
        surf3_reg   <= surf2_reg;
        surf4_reg   <= surf3_reg;
        dot_reg     <= dot_next;
        inside2_reg <= inside_next;
        ld_reg      <= $signed({1'b0, level}) * dot_reg;
        inside3_reg <= inside2_reg;
        inside4_reg <= inside3_reg;
        tneg_reg    <= t[51];
        result_reg.out_red   <= out_next[0];
        result_reg.out_green <= out_next[1];
        result_reg.out_blue  <= out_next[2];
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire
